// ----- sv/vtp_pkg.sv -----
// Shared constants and types for the vertex transform block.
`timescale 1ns / 1ps

package vtp_pkg;

    localparam int NUM_PAIRS  = 8;
    localparam int PAIR_W     = 64;
    localparam int PAIR_IDX_W = 3;
    localparam int COORD_W    = 32;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int SUM_W      = PROD_W + 2;

    localparam logic KIND_FULL  = 1'b0;
    localparam logic KIND_POINT = 1'b1;

    typedef logic [PAIR_W-1:0] pair_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    localparam pair_t COEF_RESET [NUM_PAIRS] = '{
        64'h0000_0000_8000_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

endpackage

// ----- sv/vertex_transform_perspective.sv -----
// Pipelined 4x4 fixed-point vertex transform with perspective divide.
// Stages, in order: multiply, sum, clip, one restoring divide stage
// per quotient bit, and the output register.
// Throughput: one transaction per cycle; the whole pipe holds on a stall.
// Reset: synchronous active-low aresetn clears valid bits and loads the
// default matrix into the coefficient registers.
`timescale 1ns / 1ps

module vertex_transform_perspective
    import vtp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [PAIR_IDX_W-1:0] cfg_index,
    input  logic [PAIR_W-1:0]     cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_kind,
    input  logic signed [31:0]    s_in_x,
    input  logic signed [31:0]    s_in_y,
    input  logic signed [31:0]    s_in_z,
    input  logic signed [31:0]    s_in_w,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [31:0]    m_out_x,
    output logic signed [31:0]    m_out_y,
    output logic signed [31:0]    m_out_z,
    output logic signed [31:0]    m_out_w,
    output logic                  m_saturated,
    output logic                  m_w_was_zero
);

    localparam int DW = COORD_W + FRAC_BITS;
    localparam int RW = COORD_W + 1;
    localparam logic [DW-1:0] Q_NEG_LIM = DW'(1) << (COORD_W - 1);
    localparam logic [DW-1:0] Q_POS_LIM = Q_NEG_LIM - DW'(1);
    localparam sum_t MAX_S = sum_t'(32'sh7FFF_FFFF);
    localparam sum_t MIN_S = sum_t'(32'sh8000_0000);

    pair_t coef_reg [NUM_PAIRS];
    logic  adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= COEF_RESET;
        end else if (cfg_wr_en) begin
            coef_reg[cfg_index] <= cfg_wdata;
        end
    end

    // multiply stage
    coord_t elem [4][4];
    coord_t vin  [4];
    prod_t  prod_next [4][4];
    prod_t  prod_reg  [4][4];
    logic   mul_valid_reg, mul_kind_reg;

    always_comb begin
        vin[0] = s_in_x;
        vin[1] = s_in_y;
        vin[2] = s_in_z;
        vin[3] = (s_kind == KIND_POINT) ? coord_t'(32'sd1 <<< FRAC_BITS) : s_in_w;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                elem[r][c] = ((c * 4 + r) % 2 == 1)
                    ? coord_t'(coef_reg[(c * 4 + r) / 2][63:32])
                    : coord_t'(coef_reg[(c * 4 + r) / 2][31:0]);
                prod_next[r][c] = prod_t'(elem[r][c]) * prod_t'(vin[c]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (adv) begin
            mul_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg     <= prod_next;
            mul_kind_reg <= s_kind;
        end
    end

    // sum stage
    sum_t sum_next [4];
    sum_t sum_reg  [4];
    logic sum_valid_reg, sum_kind_reg;

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            sum_next[r] = sum_t'(prod_reg[r][0]) + sum_t'(prod_reg[r][1])
                        + sum_t'(prod_reg[r][2]) + sum_t'(prod_reg[r][3]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
        end else if (adv) begin
            sum_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_reg      <= sum_next;
            sum_kind_reg <= mul_kind_reg;
        end
    end

    // shift and clip stage, feeds divider stage 0
    sum_t   sh [4];
    coord_t clip_next [4];
    logic   clip_sat_next;

    always_comb begin
        clip_sat_next = 1'b0;
        for (int r = 0; r < 4; r++) begin
            sh[r] = sum_reg[r] >>> FRAC_BITS;
            if (sh[r] > MAX_S) begin
                clip_next[r]  = coord_t'(32'sh7FFF_FFFF);
                clip_sat_next = 1'b1;
            end else if (sh[r] < MIN_S) begin
                clip_next[r]  = coord_t'(32'sh8000_0000);
                clip_sat_next = 1'b1;
            end else begin
                clip_next[r] = coord_t'(sh[r][COORD_W-1:0]);
            end
        end
    end

    logic                dv_valid_reg [DW+1];
    logic                dv_kind_reg  [DW+1];
    logic                dv_sat_reg   [DW+1];
    logic                dv_wz_reg    [DW+1];
    logic [COORD_W-1:0]  dv_dmag_reg  [DW+1];
    logic                dv_wneg_reg  [DW+1];
    coord_t              dv_res_reg   [DW+1][4];
    logic [RW-2:0]       dv_rem_reg   [DW+1][3];
    logic [DW-1:0]       dv_dq_reg    [DW+1][3];

    logic [COORD_W-1:0] vmag [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            vmag[k] = clip_next[k][COORD_W-1] ? (COORD_W'(0) - clip_next[k])
                                               : clip_next[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_valid_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_valid_reg[0] <= sum_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_kind_reg[0] <= sum_kind_reg;
            dv_sat_reg[0]  <= clip_sat_next;
            dv_wz_reg[0]   <= (sum_kind_reg == KIND_POINT) && (clip_next[3] == '0);
            dv_wneg_reg[0] <= clip_next[3][COORD_W-1];
            dv_dmag_reg[0] <= clip_next[3][COORD_W-1] ? (COORD_W'(0) - clip_next[3])
                                                       : clip_next[3];
            dv_res_reg[0]  <= clip_next;
            for (int k = 0; k < 3; k++) begin
                dv_rem_reg[0][k] <= '0;
                dv_dq_reg[0][k]  <= {vmag[k], FRAC_BITS'(0)};
            end
        end
    end

    // restoring divide, one quotient bit per stage
    for (genvar i = 1; i <= DW; i++) begin : g_div
        logic [RW-1:0]  cand [3];
        logic [RW-2:0]  rem_next [3];
        logic [DW-1:0]  dq_next [3];

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                cand[k] = {dv_rem_reg[i-1][k], dv_dq_reg[i-1][k][DW-1]};
                if (cand[k] >= {1'b0, dv_dmag_reg[i-1]}) begin
                    rem_next[k] = (RW-1)'(cand[k] - {1'b0, dv_dmag_reg[i-1]});
                    dq_next[k]  = {dv_dq_reg[i-1][k][DW-2:0], 1'b1};
                end else begin
                    rem_next[k] = cand[k][RW-2:0];
                    dq_next[k]  = {dv_dq_reg[i-1][k][DW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[i] <= 1'b0;
            end else if (adv) begin
                dv_valid_reg[i] <= dv_valid_reg[i-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_kind_reg[i] <= dv_kind_reg[i-1];
                dv_sat_reg[i]  <= dv_sat_reg[i-1];
                dv_wz_reg[i]   <= dv_wz_reg[i-1];
                dv_wneg_reg[i] <= dv_wneg_reg[i-1];
                dv_dmag_reg[i] <= dv_dmag_reg[i-1];
                dv_res_reg[i]  <= dv_res_reg[i-1];
                dv_rem_reg[i]  <= rem_next;
                dv_dq_reg[i]   <= dq_next;
            end
        end
    end

    // sign fix, clip and output register
    coord_t out_next [3];
    logic   out_sat_next;
    logic   do_div;
    logic   qneg [3];
    logic [DW-1:0] q [3];

    always_comb begin
        do_div       = (dv_kind_reg[DW] == KIND_POINT) && !dv_wz_reg[DW];
        out_sat_next = dv_sat_reg[DW];
        for (int k = 0; k < 3; k++) begin
            q[k]    = dv_dq_reg[DW][k];
            qneg[k] = dv_res_reg[DW][k][COORD_W-1] ^ dv_wneg_reg[DW];
            out_next[k] = dv_res_reg[DW][k];
            if (do_div) begin
                if (qneg[k]) begin
                    if (q[k] > Q_NEG_LIM) begin
                        out_next[k]  = coord_t'(32'sh8000_0000);
                        out_sat_next = 1'b1;
                    end else begin
                        out_next[k] = coord_t'(COORD_W'(0) - q[k][COORD_W-1:0]);
                    end
                end else begin
                    if (q[k] > Q_POS_LIM) begin
                        out_next[k]  = coord_t'(32'sh7FFF_FFFF);
                        out_sat_next = 1'b1;
                    end else begin
                        out_next[k] = coord_t'(q[k][COORD_W-1:0]);
                    end
                end
            end
        end
    end

    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dv_valid_reg[DW];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_out_x      <= out_next[0];
            m_out_y      <= out_next[1];
            m_out_z      <= out_next[2];
            m_out_w      <= dv_res_reg[DW][3];
            m_saturated  <= out_sat_next;
            m_w_was_zero <= dv_wz_reg[DW];
        end
    end

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = m_valid_reg;

endmodule
